// ===== rtl/core/wbps_pkg.sv =====
package wbps_pkg;

    localparam int BYTE_W       = 8;
    localparam int PAT_BYTES    = 16;
    localparam int PAT_IDX_W    = 4;
    localparam int HALF_BYTES   = 8;
    localparam int CFG_DATA_W   = 64;
    localparam int CFG_IDX_W    = 3;
    localparam int LEN_W        = 5;
    localparam int OUT_OFFSET_W = 32;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PATTERN_LOW  = 3'd0,
        CFG_PATTERN_HIGH = 3'd1,
        CFG_WILDCARD     = 3'd2,
        CFG_LENGTH       = 3'd3,
        CFG_SKIP_MODE    = 3'd4
    } t_cfg_idx;

    typedef struct packed {
        logic [PAT_BYTES-1:0][BYTE_W-1:0] pattern;
        logic [PAT_BYTES-1:0]             wildcard_mask;
        logic [LEN_W-1:0]                 pattern_length;
        logic                             skip_mode;
    } t_cfg;

endpackage

// ===== rtl/core/wbps_in_if.sv =====
interface wbps_in_if;
    logic                          valid;
    logic                          ready;
    logic [wbps_pkg::BYTE_W-1:0]   data_byte;
    logic                          last_byte;

    modport source (output valid, data_byte, last_byte, input ready);
    modport sink   (input valid, data_byte, last_byte, output ready);
endinterface

// ===== rtl/core/wbps_out_if.sv =====
interface wbps_out_if;
    logic                                valid;
    logic                                ready;
    logic                                found;
    logic [wbps_pkg::OUT_OFFSET_W-1:0]   match_offset;

    modport source (output valid, found, match_offset, input ready);
    modport sink   (input valid, found, match_offset, output ready);
endinterface

// ===== rtl/core/wbps_cfg_regs.sv =====
module wbps_cfg_regs (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [wbps_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [wbps_pkg::CFG_DATA_W-1:0]   i_cfg_wdata,
    output wbps_pkg::t_cfg                    o_cfg
);

    wbps_pkg::t_cfg r_cfg;
    wbps_pkg::t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            unique case (wbps_pkg::t_cfg_idx'(i_cfg_index))
                wbps_pkg::CFG_PATTERN_LOW: begin
                    n_cfg.pattern[wbps_pkg::HALF_BYTES-1:0] = i_cfg_wdata;
                end
                wbps_pkg::CFG_PATTERN_HIGH: begin
                    n_cfg.pattern[wbps_pkg::PAT_BYTES-1:wbps_pkg::HALF_BYTES] = i_cfg_wdata;
                end
                wbps_pkg::CFG_WILDCARD: begin
                    n_cfg.wildcard_mask = i_cfg_wdata[wbps_pkg::PAT_BYTES-1:0];
                end
                wbps_pkg::CFG_LENGTH: begin
                    n_cfg.pattern_length = i_cfg_wdata[wbps_pkg::LEN_W-1:0];
                end
                wbps_pkg::CFG_SKIP_MODE: begin
                    n_cfg.skip_mode = i_cfg_wdata[0];
                end
                default: begin
                    n_cfg = r_cfg;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '{pattern:        '0,
                       wildcard_mask:  '0,
                       pattern_length: wbps_pkg::LEN_W'(1),
                       skip_mode:      1'b0};
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ===== rtl/core/wbps_match.sv =====
module wbps_match #(
    parameter int MAX_PATTERN = 16,
    parameter int PROG_W      = $clog2(MAX_PATTERN + 1),
    parameter int IDX_W       = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1
) (
    input  wbps_pkg::t_cfg                 i_cfg,
    input  logic [wbps_pkg::BYTE_W-1:0]    i_win [MAX_PATTERN],
    input  logic [PROG_W-1:0]              i_prog,
    output logic [PROG_W-1:0]              o_len,
    output logic                           o_hit,
    output logic [PROG_W-1:0]              o_next_prog
);

    localparam logic [wbps_pkg::LEN_W-1:0] LEN_CAP  = wbps_pkg::LEN_W'(MAX_PATTERN);
    localparam logic [PROG_W:0]            FILL_CAP = (PROG_W + 1)'(MAX_PATTERN);

    logic [PROG_W-1:0]             w_len;
    logic [PROG_W:0]               w_fill_raw;
    logic [PROG_W-1:0]             w_fill;
    logic                          w_full_hit;
    logic [PROG_W-1:0]             w_j;
    logic [PROG_W:0]               w_j_inc;
    logic [wbps_pkg::PAT_IDX_W-1:0] w_j_idx;
    logic                          w_j_match;
    logic [IDX_W-1:0]              w_win_idx;
    logic [wbps_pkg::PAT_IDX_W-1:0] w_pat_idx;

    // zero taken as one, anything past the window as the window
    always_comb begin
        if (i_cfg.pattern_length == '0) begin
            w_len = PROG_W'(1);
        end else if (i_cfg.pattern_length > LEN_CAP) begin
            w_len = PROG_W'(MAX_PATTERN);
        end else begin
            w_len = PROG_W'(i_cfg.pattern_length);
        end
    end

    // full mode: compare the last w_len bytes, the oldest of them against pattern byte 0
    always_comb begin
        w_fill_raw = {1'b0, i_prog} + (PROG_W + 1)'(1);
        w_fill     = (w_fill_raw > FILL_CAP) ? PROG_W'(MAX_PATTERN) : w_fill_raw[PROG_W-1:0];
        w_full_hit = (w_fill >= w_len);
        w_win_idx  = '0;
        w_pat_idx  = '0;
        for (int k = 0; k < MAX_PATTERN; k++) begin
            if (PROG_W'(k) < w_len) begin
                w_win_idx = IDX_W'(w_len - PROG_W'(1) - PROG_W'(k));
                w_pat_idx = wbps_pkg::PAT_IDX_W'(k);
                if (!(i_cfg.wildcard_mask[w_pat_idx] ||
                      (i_cfg.pattern[w_pat_idx] == i_win[w_win_idx]))) begin
                    w_full_hit = 1'b0;
                end
            end
        end
    end

    // skip mode: a single candidate
    always_comb begin
        w_j       = (i_prog >= w_len) ? '0 : i_prog;
        w_j_idx   = wbps_pkg::PAT_IDX_W'(w_j);
        w_j_match = i_cfg.wildcard_mask[w_j_idx] || (i_cfg.pattern[w_j_idx] == i_win[0]);
        w_j_inc   = {1'b0, w_j} + (PROG_W + 1)'(1);
    end

    always_comb begin
        o_len = w_len;
        if (i_cfg.skip_mode) begin
            if (w_j_match && (w_j_inc == {1'b0, w_len})) begin
                o_hit       = 1'b1;
                o_next_prog = '0;
            end else if (w_j_match) begin
                o_hit       = 1'b0;
                o_next_prog = w_j_inc[PROG_W-1:0];
            end else begin
                o_hit       = 1'b0;
                o_next_prog = '0;
            end
        end else begin
            o_hit       = w_full_hit;
            o_next_prog = w_fill;
        end
    end

endmodule

// ===== rtl/core/wildcard_byte_pattern_search_unit.sv =====
// Finds the first occurrence of a pattern of up to MAX_PATTERN bytes, each a fixed
// byte or a wildcard, in a byte stream. One byte can be taken every clock cycle while the
// output is not stalled; the match for a byte is computed from the input register through
// a parallel compare of the window of recent bytes, and a result beat is registered in the
// output register. While a result beat waits for the receiver, the byte in the input
// register waits too and the input stalls. A result beat is sent at the first hit
// (found, start offset) or on the last byte of a buffer without a hit; bytes after a
// hit are dropped until the last byte, which clears the search state. Configuration
// registers should be written between beats.
module wildcard_byte_pattern_search_unit #(
    parameter int MAX_PATTERN = 16,
    parameter int OFFSET_BITS = 32
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [wbps_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [wbps_pkg::CFG_DATA_W-1:0]   i_cfg_wdata,
    wbps_in_if.sink                           i_byte_stream,
    wbps_out_if.source                        o_result
);

    localparam int PROG_W = $clog2(MAX_PATTERN + 1);

    wbps_pkg::t_cfg w_cfg;

    logic                          r_in_vld,  n_in_vld;
    logic [wbps_pkg::BYTE_W-1:0]   r_in_byte, n_in_byte;
    logic                          r_in_last, n_in_last;

    logic [wbps_pkg::BYTE_W-1:0]   r_win [MAX_PATTERN];
    logic [wbps_pkg::BYTE_W-1:0]   n_win [MAX_PATTERN];
    logic [wbps_pkg::BYTE_W-1:0]   w_win [MAX_PATTERN];
    logic [OFFSET_BITS-1:0]        r_pos,  n_pos;
    logic [PROG_W-1:0]             r_prog, n_prog;
    logic                          r_done, n_done;

    logic                              r_out_vld,    n_out_vld;
    logic                              r_out_found,  n_out_found;
    logic [wbps_pkg::OUT_OFFSET_W-1:0] r_out_offset, n_out_offset;

    logic                          w_fire;
    logic                          w_in_ready;
    logic [PROG_W-1:0]             w_len;
    logic                          w_hit;
    logic [PROG_W-1:0]             w_next_prog;
    logic [OFFSET_BITS-1:0]        w_start;

    wbps_cfg_regs u_cfg_regs (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (w_cfg)
    );

    always_comb begin
        w_win[0] = r_in_byte;
        for (int i = 1; i < MAX_PATTERN; i++) begin
            w_win[i] = r_win[i-1];
        end
    end

    wbps_match #(
        .MAX_PATTERN (MAX_PATTERN)
    ) u_match (
        .i_cfg       (w_cfg),
        .i_win       (w_win),
        .i_prog      (r_prog),
        .o_len       (w_len),
        .o_hit       (w_hit),
        .o_next_prog (w_next_prog)
    );

    assign w_fire     = r_in_vld && (!r_out_vld || o_result.ready);
    assign w_in_ready = !r_in_vld || w_fire;
    assign w_start    = r_pos + OFFSET_BITS'(1) - OFFSET_BITS'(w_len);

    assign i_byte_stream.ready = w_in_ready;
    assign o_result.valid        = r_out_vld;
    assign o_result.found        = r_out_found;
    assign o_result.match_offset = r_out_offset;

    always_comb begin
        n_in_vld     = r_in_vld;
        n_in_byte    = r_in_byte;
        n_in_last    = r_in_last;
        n_win        = r_win;
        n_pos        = r_pos;
        n_prog       = r_prog;
        n_done       = r_done;
        n_out_vld    = r_out_vld && !o_result.ready;
        n_out_found  = r_out_found;
        n_out_offset = r_out_offset;

        if (i_byte_stream.valid && w_in_ready) begin
            n_in_vld  = 1'b1;
            n_in_byte = i_byte_stream.data_byte;
            n_in_last = i_byte_stream.last_byte;
        end else if (w_fire) begin
            n_in_vld  = 1'b0;
        end

        if (w_fire && !r_done) begin
            n_win  = w_win;
            n_prog = w_next_prog;
            n_pos  = r_pos + OFFSET_BITS'(1);
            if (w_hit || r_in_last) begin
                n_out_vld    = 1'b1;
                n_out_found  = w_hit;
                n_out_offset = w_hit ? wbps_pkg::OUT_OFFSET_W'(w_start) : '0;
            end
            if (w_hit) begin
                n_done = 1'b1;
            end
        end

        if (w_fire && r_in_last) begin
            for (int i = 0; i < MAX_PATTERN; i++) begin
                n_win[i] = '0;
            end
            n_pos  = '0;
            n_prog = '0;
            n_done = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        r_in_byte    <= n_in_byte;
        r_in_last    <= n_in_last;
        r_out_found  <= n_out_found;
        r_out_offset <= n_out_offset;
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
            for (int i = 0; i < MAX_PATTERN; i++) begin
                r_win[i] <= '0;
            end
            r_pos     <= '0;
            r_prog    <= '0;
            r_done    <= 1'b0;
        end else begin
            r_in_vld  <= n_in_vld;
            r_out_vld <= n_out_vld;
            r_win     <= n_win;
            r_pos     <= n_pos;
            r_prog    <= n_prog;
            r_done    <= n_done;
        end
    end

    a_not_found_zero_offset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld && !r_out_found |-> r_out_offset == '0)
        else $error("miss beat carries a non-zero offset");

    a_finished_holds_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_fire && r_done && !r_in_last |=> r_pos == $past(r_pos) && r_done)
        else $error("position moved after a hit");

    a_last_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_fire && r_in_last |=> r_pos == '0 && r_prog == '0 && !r_done)
        else $error("state not cleared after last byte");

    a_in_reg_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_vld && !w_fire |=> r_in_vld && $stable(r_in_byte) && $stable(r_in_last))
        else $error("pending byte overwritten");

    a_result_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_fire && r_in_last && !r_done |=> r_out_vld)
        else $error("no result beat for last byte");

endmodule

// ===== sim/wildcard_byte_pattern_search_unit_tb.sv =====
module wildcard_byte_pattern_search_unit_tb;
    import wbps_pkg::*;

    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              last;
    } t_stream_byte;

    typedef struct packed {
        logic                    found;
        logic [OUT_OFFSET_W-1:0] offset;
    } t_search_result;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_wdata;

    wbps_in_if  byte_if ();
    wbps_out_if result_if ();

    wildcard_byte_pattern_search_unit u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_byte_stream (byte_if),
        .o_result      (result_if)
    );

    t_stream_byte   bytes_to_send [$];
    t_search_result results_due [$];
    t_search_result oldest_due;

    // predictor state and register copy
    t_cfg              model_cfg;
    logic [BYTE_W-1:0] window [PAT_BYTES];
    logic [31:0]       scan_pos;
    int unsigned       scan_progress;
    bit                hit_reported;

    int mismatches    = 0;
    int bytes_queued  = 0;
    int send_gap      = 0;
    int hold_left     = 0;
    bit calm          = 0;
    bit long_hold_req = 0;
    bit long_hold_done = 0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #5_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    function automatic int unsigned live_length();
        int unsigned len;
        len = 32'(model_cfg.pattern_length);
        if (len < 1) len = 1;
        if (len > PAT_BYTES) len = PAT_BYTES;
        return len;
    endfunction

    function automatic bit byte_fits(int unsigned k, logic [BYTE_W-1:0] b);
        return model_cfg.wildcard_mask[k % 16] || (model_cfg.pattern[k % 16] == b);
    endfunction

    task automatic clear_scan();
        for (int k = 0; k < PAT_BYTES; k++) window[k] = '0;
        scan_pos      = '0;
        scan_progress = 0;
        hit_reported  = 1'b0;
    endtask

    task automatic scan_byte(logic [BYTE_W-1:0] b, logic last);
        int unsigned len;
        int unsigned j;
        int unsigned fill;
        bit          hit;
        logic [31:0] start;
        len = live_length();
        hit = 1'b0;
        if (hit_reported) begin
            if (last) clear_scan();
        end else begin
            for (int k = PAT_BYTES - 1; k > 0; k--) window[k] = window[k-1];
            window[0] = b;
            if (model_cfg.skip_mode) begin
                j = scan_progress;
                if (j >= len) j = 0;
                if (byte_fits(j, b)) begin
                    j++;
                    if (j == len) begin
                        hit = 1'b1;
                        j   = 0;
                    end
                end else begin
                    j = 0;
                end
                scan_progress = j;
            end else begin
                fill = scan_progress + 1;
                if (fill > PAT_BYTES) fill = PAT_BYTES;
                scan_progress = fill;
                if (fill >= len) begin
                    hit = 1'b1;
                    for (int k = 0; k < len; k++)
                        if (!byte_fits(k, window[(len - 1 - k) % 16])) hit = 1'b0;
                end
            end
            start    = scan_pos + 32'd1 - 32'(len);
            scan_pos = scan_pos + 32'd1;
            if (hit) begin
                results_due.push_back('{1'b1, start});
                if (last) clear_scan();
                else hit_reported = 1'b1;
            end else if (last) begin
                results_due.push_back('{1'b0, 32'd0});
                clear_scan();
            end
        end
    endtask

    task automatic write_reg(t_cfg_idx idx, logic [CFG_DATA_W-1:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        case (idx)
            CFG_PATTERN_LOW:  model_cfg.pattern[7:0]   = val;
            CFG_PATTERN_HIGH: model_cfg.pattern[15:8]  = val;
            CFG_WILDCARD:     model_cfg.wildcard_mask  = val[15:0];
            CFG_LENGTH:       model_cfg.pattern_length = val[LEN_W-1:0];
            CFG_SKIP_MODE:    model_cfg.skip_mode      = val[0];
            default: ;
        endcase
    endtask

    task automatic apply_setting(logic [63:0] lo, logic [63:0] hi, logic [15:0] mask,
                                 logic [4:0] len, logic skip);
        write_reg(CFG_PATTERN_LOW, lo);
        write_reg(CFG_PATTERN_HIGH, hi);
        write_reg(CFG_WILDCARD, {48'd0, mask});
        write_reg(CFG_LENGTH, {59'd0, len});
        write_reg(CFG_SKIP_MODE, {63'd0, skip});
        i_cfg_we <= 1'b0;
    endtask

    // bytes listed in stream order, first byte in the highest lane
    task automatic queue_bytes(logic [127:0] seq, int n, bit closes);
        for (int i = 0; i < n; i++) begin
            bytes_to_send.push_back('{seq[8*(n-1-i) +: 8], closes && (i == n - 1)});
            bytes_queued++;
        end
    endtask

    task automatic queue_random_buffer(bit closes);
        logic [BYTE_W-1:0] pick [64];
        int unsigned       len;
        int                n;
        int                at;
        len = live_length();
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 64) : $urandom_range(1, 16);
        for (int i = 0; i < n; i++) begin
            case ($urandom_range(0, 4))
                0, 1:    pick[i] = model_cfg.pattern[$urandom_range(0, len - 1)];
                2:       pick[i] = 8'($urandom_range(0, 255));
                3:       pick[i] = model_cfg.pattern[i % len];
                default: pick[i] = $urandom_range(0, 1) ? 8'hFF : 8'h00;
            endcase
        end
        if (n >= len && $urandom_range(0, 1)) begin
            at = $urandom_range(0, n - len);
            for (int k = 0; k < len; k++)
                pick[at+k] = model_cfg.wildcard_mask[k] ? 8'($urandom_range(0, 255))
                                                        : model_cfg.pattern[k];
        end
        for (int i = 0; i < n; i++) begin
            bytes_to_send.push_back('{pick[i], closes && (i == n - 1)});
            bytes_queued++;
        end
    endtask

    task automatic wait_idle();
        do @(posedge i_clk);
        while (bytes_to_send.size() != 0 || byte_if.valid || results_due.size() != 0);
        repeat (4) @(posedge i_clk);
    endtask

    // sender
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            byte_if.valid <= 1'b0;
            send_gap = 0;
        end else begin
            if (byte_if.valid && byte_if.ready)
                scan_byte(byte_if.data_byte, byte_if.last_byte);
            if (!byte_if.valid || byte_if.ready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    byte_if.valid <= 1'b0;
                end else if (bytes_to_send.size() == 0) begin
                    byte_if.valid <= 1'b0;
                end else if (!calm && $urandom_range(0, 9) == 0) begin
                    send_gap = $urandom_range(0, 4);
                    byte_if.valid <= 1'b0;
                end else begin
                    byte_if.valid     <= 1'b1;
                    byte_if.data_byte <= bytes_to_send[0].data;
                    byte_if.last_byte <= bytes_to_send[0].last;
                    void'(bytes_to_send.pop_front());
                end
            end
        end
    end

    // receiver and checker
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            result_if.ready <= 1'b0;
            hold_left = 0;
        end else begin
            if (result_if.valid && result_if.ready) begin
                if (results_due.size() == 0) begin
                    $error("found: expected no beat, got %0b (match_offset %0d)",
                           result_if.found, result_if.match_offset);
                    mismatches++;
                end else begin
                    oldest_due = results_due.pop_front();
                    if (result_if.found !== oldest_due.found) begin
                        $error("found: expected %0b, got %0b",
                               oldest_due.found, result_if.found);
                        mismatches++;
                    end
                    if (result_if.match_offset !== oldest_due.offset) begin
                        $error("match_offset: expected %0d, got %0d",
                               oldest_due.offset, result_if.match_offset);
                        mismatches++;
                    end
                end
            end
            if (hold_left > 0) begin
                hold_left--;
                result_if.ready <= 1'b0;
            end else if (long_hold_req && !long_hold_done) begin
                long_hold_done = 1'b1;
                hold_left = 399;
                result_if.ready <= 1'b0;
            end else if (!calm && $urandom_range(0, 7) == 0) begin
                hold_left = $urandom_range(0, 4);
                result_if.ready <= 1'b0;
            end else begin
                result_if.ready <= 1'b1;
            end
        end
    end

    initial begin
        logic [63:0] lo;
        logic [63:0] hi;
        logic [15:0] mask;
        logic [4:0]  len;
        int          phase;
        int          nbuf;

        i_rst_n             = 1'b0;
        i_cfg_we            = 1'b0;
        i_cfg_index         = '0;
        i_cfg_wdata         = '0;
        byte_if.valid       = 1'b0;
        byte_if.data_byte   = '0;
        byte_if.last_byte   = 1'b0;
        result_if.ready     = 1'b0;
        model_cfg                = '0;
        model_cfg.pattern_length = 5'd1;
        clear_scan();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        // reset pattern: single zero byte, hit on the last byte
        queue_bytes(128'(16'h55_00), 2, 1'b1);
        wait_idle();
        // zero length taken as one; bytes after the hit are dropped
        apply_setting(64'h0000_0000_0000_00FF, 64'hFFFF_FFFF_FFFF_FFFF, 16'h0000, 5'd0, 1'b0);
        queue_bytes(128'(32'h00_FF_12_34), 4, 1'b1);
        wait_idle();
        // oversized length clamps to 16; buffer shorter than pattern
        apply_setting(64'h0, 64'h0, 16'hFFFF, 5'd31, 1'b0);
        queue_bytes(128'(40'h00_FF_00_FF_00), 5, 1'b1);
        wait_idle();
        // "AB?D" in skip mode, then the same buffer with every offset tried
        apply_setting(64'h0000_0000_4400_4241, 64'h0, 16'h0004, 5'd4, 1'b1);
        queue_bytes(128'(40'h41_41_42_7E_44), 5, 1'b1);
        wait_idle();
        write_reg(CFG_SKIP_MODE, 64'd0);
        i_cfg_we <= 1'b0;
        queue_bytes(128'(40'h41_41_42_7E_44), 5, 1'b1);
        wait_idle();
        // mode switched part way through a buffer
        write_reg(CFG_SKIP_MODE, 64'd1);
        i_cfg_we <= 1'b0;
        queue_bytes(128'(16'h41_42), 2, 1'b0);
        wait_idle();
        write_reg(CFG_SKIP_MODE, 64'd0);
        i_cfg_we <= 1'b0;
        queue_bytes(128'(24'h99_44_41), 3, 1'b1);
        wait_idle();

        phase = 0;
        while (bytes_queued < 1526) begin
            case ($urandom_range(0, 5))
                0: begin lo = '0; hi = '0; end
                1: begin lo = '1; hi = '1; end
                default: begin
                    lo = {$urandom, $urandom};
                    hi = {$urandom, $urandom};
                end
            endcase
            case ($urandom_range(0, 3))
                0:       mask = 16'h0000;
                1:       mask = 16'hFFFF;
                2:       mask = 16'($urandom);
                default: mask = 16'($urandom & $urandom & $urandom);
            endcase
            case ($urandom_range(0, 5))
                0:       len = 5'd1;
                1:       len = 5'd16;
                2:       len = 5'($urandom_range(0, 31));
                default: len = 5'($urandom_range(1, 5));
            endcase
            apply_setting(lo, hi, mask, len, 1'($urandom_range(0, 1)));
            nbuf = (phase == 0) ? 8 : $urandom_range(2, 6);
            for (int i = 0; i < nbuf; i++) queue_random_buffer(1'b1);
            if ($urandom_range(0, 4) == 0) queue_random_buffer(1'b0);
            if (phase == 0) long_hold_req = 1'b1;
            wait_idle();
            if (bytes_queued > 1300) calm = 1'b1;
            phase++;
        end

        repeat (10) @(posedge i_clk);
        if (mismatches == 0 && results_due.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
